// File: hdl/tcw_pkg.sv
// Shared constants, types and helpers for the text console writer.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_SPACES = 4;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int TAB_W      = $clog2(TAB_SPACES + 1);
  localparam int CELL_W     = 16;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h5f;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0a;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_HOME  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  // Linear cell index of a row/column pair.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    return a;
  endfunction

endpackage

// File: hdl/tcw_cell_store.sv
// Screen cell memory: one write port, one registered read port.
module tcw_cell_store (
  input  logic                            clk,
  input  tcw_pkg::mem_wr_t                wr,
  input  tcw_pkg::mem_rd_t                rd,
  output logic [tcw_pkg::CELL_W-1:0]      rd_data
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// File: hdl/text_console_writer.sv
// Text console writer: screen store, cursor and command sequencer.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall   | kind, char_code, read_row, read_col
//  out     | output    | out_valid / out_stall | cursor_row, cursor_col, cell_char,
//          |           |                      | cell_attr, scrolled
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (default attribute)
//
// A backspace off cell 0 and an on-screen read first read the cell, then write it back
// or capture it; a tab puts TAB_SPACES blanks and a clear blanks every cell. A scroll
// copies one cell per cycle, then blanks the bottom row. After rst, a pass blanks the
// screen with in_stall high; config writes are taken then. A stalled result waits in
// the output register and holds the sequencer.
module text_console_writer (
  input  logic       clk,
  input  logic       rst,
  // input words
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  // result words
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] cursor_row,
  output logic [6:0] cursor_col,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attr,
  output logic       scrolled,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import tcw_pkg::*;

  typedef enum logic [7:0] {
    ST_INIT   = 8'b0000_0001,  // power-up blanking pass
    ST_IDLE   = 8'b0000_0010,
    ST_PUT    = 8'b0000_0100,  // tab blanks, one per cycle unless a scroll intervenes
    ST_SCROLL = 8'b0000_1000,  // copy rows up
    ST_BLANK  = 8'b0001_0000,  // blank sweep (bottom row or whole screen)
    ST_RMW    = 8'b0010_0000,  // backspace write-back
    ST_READ   = 8'b0100_0000,  // cell read capture
    ST_DONE   = 8'b1000_0000   // hand result to output register
  } state_t;

  localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);

  state_t            state, state_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ADDR_W-1:0] sweep, sweep_next;
  logic [TAB_W-1:0]  put_left, put_left_next;
  logic [7:0]        res_char, res_char_next;
  logic [7:0]        res_attr, res_attr_next;
  logic              res_scrolled, res_scrolled_next;
  logic [7:0]        default_attribute;

  mem_wr_t           mem_wr;
  mem_rd_t           mem_rd;
  logic [CELL_W-1:0] rd_data;

  logic              accept;
  logic              out_free;
  logic              put_go;
  logic [7:0]        put_ch;
  logic              last_col, last_row;
  logic [ADDR_W-1:0] cur_addr;
  logic [ROW_W-1:0]  bs_row;
  logic [COL_W-1:0]  bs_col;
  logic              read_ok;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign last_col = (cur_col == COL_W'(COLUMNS - 1));
  assign last_row = (cur_row == ROW_W'(ROWS - 1));
  assign cur_addr = cell_addr(cur_row, cur_col);

  // Backspace target: one cell back, wrapping to the previous row.
  assign bs_col = (cur_col != '0) ? cur_col - COL_W'(1) : COL_W'(COLUMNS - 1);
  assign bs_row = (cur_col != '0) ? cur_row : cur_row - ROW_W'(1);

  assign read_ok = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);

  tcw_cell_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next        = state;
    cur_row_next      = cur_row;
    cur_col_next      = cur_col;
    sweep_next        = sweep;
    put_left_next     = put_left;
    res_char_next     = res_char;
    res_attr_next     = res_attr;
    res_scrolled_next = res_scrolled;
    mem_wr            = '0;
    mem_rd            = '0;
    put_go            = 1'b0;
    put_ch            = BLANK_CHAR;

    unique case (state)
      ST_INIT: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = sweep;
        mem_wr.data = {ATTR_RESET, BLANK_CHAR};
        sweep_next  = sweep + ADDR_W'(1);
        if (sweep == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          res_char_next     = '0;
          res_attr_next     = '0;
          res_scrolled_next = 1'b0;
          put_left_next     = '0;
          state_next        = ST_DONE;
          case (kind)
            KIND_WRITE: begin
              if (char_code == CHAR_BS) begin
                if (cur_row != '0 || cur_col != '0) begin
                  cur_row_next = bs_row;
                  cur_col_next = bs_col;
                  mem_rd.en    = 1'b1;
                  mem_rd.addr  = cell_addr(bs_row, bs_col);
                  state_next   = ST_RMW;
                end
              end else if (char_code == CHAR_NL) begin
                cur_col_next = '0;
                if (last_row) begin
                  res_scrolled_next = 1'b1;
                  sweep_next        = '0;
                  state_next        = ST_SCROLL;
                end else begin
                  cur_row_next = cur_row + ROW_W'(1);
                end
              end else if (char_code == CHAR_TAB) begin
                put_left_next = TAB_W'(TAB_SPACES);
                state_next    = ST_PUT;
              end else begin
                put_go = 1'b1;
                put_ch = char_code;
              end
            end
            KIND_CLEAR: begin
              cur_row_next = '0;
              cur_col_next = '0;
              sweep_next   = '0;
              state_next   = ST_BLANK;
            end
            KIND_HOME: begin
              cur_col_next = '0;
            end
            default: begin
              if (read_ok) begin
                mem_rd.en   = 1'b1;
                mem_rd.addr = cell_addr(ROW_W'(read_row), COL_W'(read_col));
                state_next  = ST_READ;
              end
            end
          endcase
        end
      end

      ST_PUT: begin
        put_go        = 1'b1;
        put_left_next = put_left - TAB_W'(1);
        state_next    = (put_left == TAB_W'(1)) ? ST_DONE : ST_PUT;
      end

      ST_SCROLL: begin
        // read cell k+COLUMNS while writing back cell k-1
        if (sweep != SCROLL_END) begin
          mem_rd.en   = 1'b1;
          mem_rd.addr = sweep + ADDR_W'(COLUMNS);
        end
        if (sweep != '0) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = sweep - ADDR_W'(1);
          mem_wr.data = rd_data;
        end
        if (sweep == SCROLL_END) begin
          state_next = ST_BLANK;
        end else begin
          sweep_next = sweep + ADDR_W'(1);
        end
      end

      ST_BLANK: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = sweep;
        mem_wr.data = {default_attribute, BLANK_CHAR};
        sweep_next  = sweep + ADDR_W'(1);
        if (sweep == LAST_CELL) begin
          state_next = (put_left != '0) ? ST_PUT : ST_DONE;
        end
      end

      ST_RMW: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = cur_addr;
        mem_wr.data = {rd_data[15:8], BLANK_CHAR};
        state_next  = ST_DONE;
      end

      ST_READ: begin
        res_char_next = rd_data[7:0];
        res_attr_next = rd_data[15:8];
        state_next    = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Character store and cursor advance; wrapping off the last cell scrolls.
    if (put_go) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = cur_addr;
      mem_wr.data = {default_attribute, put_ch};
      if (!last_col) begin
        cur_col_next = cur_col + COL_W'(1);
      end else begin
        cur_col_next = '0;
        if (!last_row) begin
          cur_row_next = cur_row + ROW_W'(1);
        end else begin
          res_scrolled_next = 1'b1;
          sweep_next        = '0;
          state_next        = ST_SCROLL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_INIT;
      sweep             <= '0;
      cur_row           <= '0;
      cur_col           <= '0;
      put_left          <= '0;
      default_attribute <= ATTR_RESET;
      out_valid         <= 1'b0;
    end else begin
      state    <= state_next;
      sweep    <= sweep_next;
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      put_left <= put_left_next;
      if (cfg_wr_en) begin
        default_attribute <= cfg_wr_data;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded when the word leaves the sequencer.
  always_ff @(posedge clk) begin
    res_char     <= res_char_next;
    res_attr     <= res_attr_next;
    res_scrolled <= res_scrolled_next;
    if (state == ST_DONE && out_free) begin
      cursor_row <= 5'(cur_row);
      cursor_col <= 7'(cur_col);
      cell_char  <= res_char;
      cell_attr  <= res_attr;
      scrolled   <= res_scrolled;
    end
  end

`ifndef SYNTHESIS
  // cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (int'(cur_row) < ROWS) && (int'(cur_col) < COLUMNS))
    else $error("cursor outside screen");

  // every accepted word starts work in the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted word dropped");

  // a scroll always leaves the cursor on the bottom row
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> (cursor_row == 5'(ROWS - 1)))
    else $error("scrolled result off bottom row");
`endif

endmodule
